// ----- sv/rge_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rge_pkg: shared types and constants of the reverse grain echo
// Field widths, fixed-point constants, state machine codes and the request
// and response bundles of the fade weight unit.
// ----------------------------------------------------------------------------
package rge_pkg;

	// Field and storage widths.
	localparam int SMP_W  = 24;   // dry input sample, Q0.23
	localparam int OUT_W  = 27;   // output and wet sample, Q3.23
	localparam int RING_W = 26;   // capture ring entry, Q2.23
	localparam int SEG_W  = 16;   // segment length
	localparam int FADE_W = 15;   // crossfade length, at most half a segment
	localparam int GAIN_W = 16;   // feedback gain, Q0.16
	localparam int MIX_W  = 17;   // mix gain, Q0.16 with 1.0 included
	localparam int PH_W   = 16;   // fade phase, Q0.16
	localparam int WT_W   = 17;   // fade weight, Q0.16 with 1.0 included
	localparam int CNT_W  = 32;   // sample counter and launch times
	localparam int ADDR_W = 4;    // configuration byte address
	localparam int DATA_W = 32;   // configuration data

	// Register reset values and caps.
	localparam logic [SEG_W-1:0]  SEG_RESET = 16'd12000;
	localparam logic [SEG_W-1:0]  SEG_MIN   = 16'd2;
	localparam logic [GAIN_W-1:0] FB_RESET  = 16'd19661;
	localparam logic [GAIN_W-1:0] FB_CAP    = 16'd58982;
	localparam logic [MIX_W-1:0]  MIX_RESET = 17'd32768;
	localparam logic [MIX_W-1:0]  UNITY     = 17'd65536;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_SEGMENT  = 2'd0;
	localparam logic [1:0] REG_FEEDBACK = 2'd1;
	localparam logic [1:0] REG_MIX      = 2'd2;

	// Crossfade = floor(3*seg/20), done as a multiply by ceil(2^22/20).
	// Exact for 3*seg below 2^18.
	localparam logic [17:0] RECIP20    = 18'd209716;
	localparam int          RECIP20_SH = 22;
	localparam int          XF_RAW_W   = 14;

	// Saturation bounds.
	localparam logic signed [RING_W-1:0] CAP_HI = 26'sh1FFFFFF;
	localparam logic signed [RING_W-1:0] CAP_LO = -26'sh2000000;
	localparam logic signed [OUT_W-1:0]  OUT_HI = 27'sh3FFFFFF;
	localparam logic signed [OUT_W-1:0]  OUT_LO = -27'sh4000000;

	// Odd polynomial for sin(pi/2 * x), Q0.16 coefficients.
	localparam logic [WT_W-1:0] POLY_A = 17'd102944;
	localparam logic [WT_W-1:0] POLY_B = 17'd42333;
	localparam logic [WT_W-1:0] POLY_C = 17'd5223;
	localparam logic [WT_W-1:0] POLY_D = 17'd307;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULFB,
		ST_WRITE,
		ST_LAUNCH,
		ST_ADDR0,
		ST_ADDR1,
		ST_DATA1,
		ST_WAITF,
		ST_TERM,
		ST_WET,
		ST_MIX,
		ST_OUT
	} rge_state_t;

	typedef enum logic [2:0] {
		FD_IDLE,
		FD_DIV,
		FD_SQ,
		FD_C1,
		FD_C2,
		FD_C3,
		FD_MUL
	} fade_state_t;

	typedef struct packed {
		logic              start;
		logic [FADE_W-1:0] num;
		logic [FADE_W-1:0] xf;
	} fade_req_t;

	typedef struct packed {
		logic            busy;
		logic [WT_W-1:0] weight;
	} fade_rsp_t;

endpackage
`default_nettype wire

// ----- sv/rge_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rge_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rge_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/rge_fade.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rge_fade: equal-power fade weight unit
// Divides num * 2^16 by the crossfade length one quotient bit per cycle, then
// evaluates the sine polynomial over five steps on one shared multiplier.
// ----------------------------------------------------------------------------
module rge_fade (
	input  logic               clk,
	input  logic               arst_n,
	input  rge_pkg::fade_req_t req,
	output rge_pkg::fade_rsp_t rsp
);

	import rge_pkg::*;

	localparam logic [3:0] DIV_LAST = 4'(PH_W - 1);

	fade_state_t       state_q, state_d;
	logic [3:0]        cnt_q;
	logic [FADE_W-1:0] rem_q, xf_q;
	logic [FADE_W:0]   rem_sh, rem_sub;
	logic              rem_ge;
	logic [PH_W-1:0]   x_q, x2_q;
	logic [WT_W-1:0]   t_q, w_q;
	logic [WT_W-1:0]   mul_a, mul_b;
	logic [2*WT_W-1:0] mul_p;
	logic [WT_W:0]     mul_hi;

	// Restoring division step: the remainder always stays below xf.
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_ge  = (rem_sh >= {1'b0, xf_q});
	assign rem_sub = rem_sh - {1'b0, xf_q};

	assign mul_p  = mul_a * mul_b;
	assign mul_hi = mul_p[2*WT_W-1:PH_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FD_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FD_DIV) begin
				cnt_q <= cnt_q + 4'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			FD_IDLE: begin
				if (req.start) begin
					state_d = FD_DIV;
				end
			end
			FD_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = FD_SQ;
				end
			end
			FD_SQ: begin
				mul_a   = {1'b0, x_q};
				mul_b   = {1'b0, x_q};
				state_d = FD_C1;
			end
			FD_C1: begin
				mul_a   = {1'b0, x2_q};
				mul_b   = POLY_D;
				state_d = FD_C2;
			end
			FD_C2: begin
				mul_a   = {1'b0, x2_q};
				mul_b   = t_q;
				state_d = FD_C3;
			end
			FD_C3: begin
				mul_a   = {1'b0, x2_q};
				mul_b   = t_q;
				state_d = FD_MUL;
			end
			FD_MUL: begin
				mul_a   = {1'b0, x_q};
				mul_b   = t_q;
				state_d = FD_IDLE;
			end
			default: state_d = FD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FD_IDLE: begin
				if (req.start) begin
					rem_q <= req.num;
					xf_q  <= req.xf;
				end
			end
			FD_DIV: begin
				rem_q <= rem_ge ? rem_sub[FADE_W-1:0] : rem_sh[FADE_W-1:0];
				x_q   <= {x_q[PH_W-2:0], rem_ge};
			end
			FD_SQ:  x2_q <= mul_hi[PH_W-1:0];
			FD_C1:  t_q  <= POLY_C - mul_hi[WT_W-1:0];
			FD_C2:  t_q  <= POLY_B - mul_hi[WT_W-1:0];
			FD_C3:  t_q  <= POLY_A - mul_hi[WT_W-1:0];
			FD_MUL: w_q  <= (mul_hi > {1'b0, UNITY}) ? UNITY : mul_hi[WT_W-1:0];
			default: ;
		endcase
	end

	assign rsp.busy   = (state_q != FD_IDLE);
	assign rsp.weight = w_q;

endmodule
`default_nettype wire

// ----- sv/reverse_grain_echo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reverse_grain_echo: reverse delay with equal-power crossfaded grains
// Captures the fed-back input into a ring and plays overlapping backward
// grains from it, blended with the dry signal.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid/in_ready and results leave on out_valid/
//   out_ready; every input transfer produces exactly one output transfer.
//   The gains and the segment length sit behind an APB-style port at byte
//   addresses 0, 4 and 8; pready is tied high, reads return the register.
//   The fade weights of each sample come from the fade weight units: a
//   restoring divider for the fade phase followed by five steps of the sine
//   polynomial on one shared multiplier.
//   The block handles one sample at a time. A finished result waits in the
//   output register while the next sample is taken and worked on; only the
//   last step stalls if that register is still full.
//   Reset returns the registers to their defaults and clears the counters
//   and grain slots. The capture ring is not cleared; a grain never reads an
//   entry that has not been written, as long as the segment length is not
//   raised past the amount of audio captured so far.
// ----------------------------------------------------------------------------
module reverse_grain_echo #(
	parameter int MAX_SEGMENT = 48000,
	parameter int RING_DEPTH  = 131072
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rge_pkg::ADDR_W-1:0]  paddr,
	input  logic [rge_pkg::DATA_W-1:0]  pwdata,
	output logic [rge_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// Input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [rge_pkg::SMP_W-1:0] in_sample,
	// Output channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [rge_pkg::OUT_W-1:0] out_sample
);

	import rge_pkg::*;

	localparam int RING_AW   = $clog2(RING_DEPTH);
	localparam int SEG_CAP_I = (MAX_SEGMENT < RING_DEPTH) ? MAX_SEGMENT : RING_DEPTH;
	localparam logic [SEG_W-1:0]   SEG_CAP   = SEG_W'(SEG_CAP_I);
	localparam logic [RING_AW:0]   RING_LEN  = (RING_AW + 1)'(RING_DEPTH);
	localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

	// Floor of v / 2^16 after adding one half: round half up.
	function automatic logic signed [29:0] rnd16(input logic signed [45:0] v);
		logic signed [45:0] t;
		t = v + 46'sd32768;
		return t[45:16];
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [SEG_W-1:0]  seg_cfg_q;
	logic [GAIN_W-1:0] fb_cfg_q;
	logic [MIX_W-1:0]  mix_cfg_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cfg_q <= SEG_RESET;
			fb_cfg_q  <= FB_RESET;
			mix_cfg_q <= MIX_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SEGMENT:  seg_cfg_q <= pwdata[SEG_W-1:0];
				REG_FEEDBACK: fb_cfg_q  <= pwdata[GAIN_W-1:0];
				REG_MIX:      mix_cfg_q <= pwdata[MIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SEGMENT:  prdata = {{(DATA_W-SEG_W){1'b0}}, seg_cfg_q};
			REG_FEEDBACK: prdata = {{(DATA_W-GAIN_W){1'b0}}, fb_cfg_q};
			REG_MIX:      prdata = {{(DATA_W-MIX_W){1'b0}}, mix_cfg_q};
			default:      prdata = '0;
		endcase
	end

	// Segment and crossfade lengths follow the segment register; they are
	// refreshed every cycle and first used in the launch step of a sample.
	logic [SEG_W-1:0]    seg_c, seg_q;
	logic [17:0]         seg3;
	logic [35:0]         xf_prod;
	logic [XF_RAW_W-1:0] xf_raw;
	logic [FADE_W-1:0]   xf_c, xf_q;

	always_comb begin
		if (seg_cfg_q < SEG_MIN) begin
			seg_c = SEG_MIN;
		end else if (seg_cfg_q > SEG_CAP) begin
			seg_c = SEG_CAP;
		end else begin
			seg_c = seg_cfg_q;
		end
		seg3    = {2'b00, seg_c} + {1'b0, seg_c, 1'b0};
		xf_prod = seg3 * RECIP20;
		xf_raw  = xf_prod[RECIP20_SH +: XF_RAW_W];
		if (xf_raw == '0) begin
			xf_c = FADE_W'(1);
		end else if ({1'b0, xf_raw} > seg_c[SEG_W-1:1]) begin
			xf_c = seg_c[SEG_W-1:1];
		end else begin
			xf_c = {1'b0, xf_raw};
		end
	end

	always_ff @(posedge clk) begin
		seg_q <= seg_c;
		xf_q  <= xf_c;
	end

	// Gains clamped to their legal ranges.
	logic [GAIN_W-1:0] fb_c;
	logic [MIX_W-1:0]  mix_c, dmix_c;

	assign fb_c   = (fb_cfg_q > FB_CAP) ? FB_CAP : fb_cfg_q;
	assign mix_c  = (mix_cfg_q > UNITY) ? UNITY : mix_cfg_q;
	assign dmix_c = UNITY - mix_c;

	// ------------------------------------------------------------------
	// Sequencer and state
	// ------------------------------------------------------------------
	rge_state_t state_q, state_d;

	logic [CNT_W-1:0]   wc_q;          // samples written so far
	logic [RING_AW-1:0] wp_q;          // ring slot of the next write
	logic [RING_AW-1:0] last_wp_q;     // ring slot of the newest sample
	logic [CNT_W-1:0]   next_launch_q;
	logic               slot_q;
	logic               primed_q;
	logic signed [OUT_W-1:0] last_wet_q;

	// Grain slots: start time, length, fade length, ring slot of the sample
	// just before the start (the first one a grain plays).
	logic [CNT_W-1:0]   start_q  [2];
	logic [SEG_W-1:0]   len_q    [2];
	logic [FADE_W-1:0]  fade_q   [2];
	logic [RING_AW-1:0] sidx_q   [2];
	logic [1:0]         active_q;

	// Per-item working registers.
	logic signed [SMP_W-1:0]  dry_q;
	logic signed [43:0]       fbp_q;
	logic [1:0]               live_q;
	logic [1:0]               infade_q;
	logic [RING_AW-1:0]       idx1_q;
	logic signed [RING_W-1:0] smp_q  [2];
	logic signed [43:0]       prod_q [2];
	logic signed [44:0]       pm_q;
	logic signed [41:0]       pd_q;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  out_sample_q;

	// Ring memory ports.
	logic               ram_we;
	logic [RING_AW-1:0] ram_raddr;
	logic [RING_W-1:0]  ram_wdata;
	logic [RING_W-1:0]  ram_rdata;

	// Fade units, one per grain slot.
	fade_req_t fade_req [2];
	fade_rsp_t fade_rsp [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ram_we   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_MULFB;
				end
			end
			ST_MULFB:  state_d = ST_WRITE;
			ST_WRITE: begin
				ram_we  = 1'b1;
				state_d = ST_LAUNCH;
			end
			ST_LAUNCH: state_d = ST_ADDR0;
			ST_ADDR0:  state_d = ST_ADDR1;
			ST_ADDR1:  state_d = ST_DATA1;
			ST_DATA1:  state_d = ST_WAITF;
			ST_WAITF: begin
				if (!fade_rsp[0].busy && !fade_rsp[1].busy) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM:   state_d = ST_WET;
			ST_WET:    state_d = ST_MIX;
			ST_MIX:    state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Feedback path: the sample fed into the ring saturates to the ring's
	// Q2.23 range.
	logic signed [29:0]       fb_r;
	logic signed [29:0]       fed_sum;
	logic signed [RING_W-1:0] fed;

	always_comb begin
		fb_r    = rnd16(46'(fbp_q));
		fed_sum = 30'(dry_q) + fb_r;
		if (fed_sum > CAP_HI) begin
			fed = CAP_HI;
		end else if (fed_sum < CAP_LO) begin
			fed = CAP_LO;
		end else begin
			fed = fed_sum[RING_W-1:0];
		end
	end

	assign ram_wdata = fed;

	// Per-slot views of the grain state against the current count.
	logic [CNT_W-1:0]   age    [2];
	logic [RING_AW:0]   diff   [2];
	logic [RING_AW-1:0] idx    [2];
	logic [SEG_W-1:0]   num    [2];
	logic [1:0]         live;
	logic [1:0]         in_fade;
	logic [1:0]         body;
	logic [1:0]         ended;

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			age[g]     = wc_q - start_q[g];
			live[g]    = active_q[g] && (age[g] < {16'd0, len_q[g]});
			ended[g]   = active_q[g] && (age[g] >= {16'd0, len_q[g]});
			body[g]    = active_q[g] &&
				(age[g] < {16'd0, len_q[g] - {1'b0, fade_q[g]}});
			in_fade[g] = (age[g] < {17'd0, fade_q[g]}) ||
				(age[g] >= {16'd0, len_q[g] - {1'b0, fade_q[g]}});
			// Backward read: the ring slot age samples before the grain's first one.
			diff[g] = {1'b0, sidx_q[g]} - {1'b0, age[g][RING_AW-1:0]};
			if (diff[g][RING_AW]) begin
				idx[g] = RING_AW'(diff[g] + RING_LEN);
			end else begin
				idx[g] = diff[g][RING_AW-1:0];
			end
			// Distance into the fade-in, or left before the end of the fade-out.
			if (!(live[g] && in_fade[g])) begin
				num[g] = '0;
			end else if (age[g] < {17'd0, fade_q[g]}) begin
				num[g] = age[g][SEG_W-1:0];
			end else begin
				num[g] = len_q[g] - SEG_W'(1) - age[g][SEG_W-1:0];
			end
			fade_req[g].start = (state_q == ST_ADDR0);
			fade_req[g].num   = num[g][FADE_W-1:0];
			fade_req[g].xf    = fade_q[g];
		end
	end

	assign ram_raddr = (state_q == ST_ADDR0) ? idx[0] : idx1_q;

	// Launch decision. The first launch comes once a whole segment has been
	// captured; later ones every segment minus crossfade samples. A slot that
	// has not yet reached its fade-out is left alone and the other one taken.
	logic             primed_now;
	logic [CNT_W-1:0] nl;
	logic [CNT_W-1:0] lag;
	logic             launch;
	logic             sel;

	always_comb begin
		primed_now = primed_q || (wc_q >= {16'd0, seg_q});
		nl         = (!primed_q && primed_now) ? wc_q : next_launch_q;
		lag        = wc_q - nl;
		launch     = primed_now && !lag[CNT_W-1];
		sel        = slot_q ^ body[slot_q];
	end

	// Grain sum and mix.
	logic [WT_W-1:0]    w_sel [2];
	logic signed [29:0] term  [2];
	logic signed [30:0] wet_sum;
	logic signed [OUT_W-1:0] wet;
	logic signed [45:0] mix_sum;
	logic signed [29:0] mix_r;
	logic signed [OUT_W-1:0] res;

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			w_sel[g] = infade_q[g] ? fade_rsp[g].weight : UNITY;
			term[g]  = live_q[g] ? rnd16(46'(prod_q[g])) : 30'sd0;
		end
		wet_sum = 31'(term[0]) + 31'(term[1]);
		if (wet_sum > OUT_HI) begin
			wet = OUT_HI;
		end else if (wet_sum < OUT_LO) begin
			wet = OUT_LO;
		end else begin
			wet = wet_sum[OUT_W-1:0];
		end
		mix_sum = 46'(pm_q) + 46'(pd_q);
		mix_r   = rnd16(mix_sum);
		if (mix_r > OUT_HI) begin
			res = OUT_HI;
		end else if (mix_r < OUT_LO) begin
			res = OUT_LO;
		end else begin
			res = mix_r[OUT_W-1:0];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q          <= '0;
			wp_q          <= '0;
			last_wp_q     <= '0;
			next_launch_q <= '0;
			slot_q        <= 1'b0;
			primed_q      <= 1'b0;
			last_wet_q    <= '0;
			active_q      <= '0;
			out_valid_q   <= 1'b0;
			for (int g = 0; g < 2; g++) begin
				start_q[g] <= '0;
				len_q[g]   <= '0;
				fade_q[g]  <= '0;
				sidx_q[g]  <= '0;
			end
		end else begin
			if (state_q == ST_WRITE) begin
				wc_q      <= wc_q + CNT_W'(1);
				last_wp_q <= wp_q;
				wp_q      <= (wp_q == RING_LAST) ? '0 : wp_q + RING_AW'(1);
			end
			if (state_q == ST_LAUNCH) begin
				primed_q <= primed_now;
				if (launch) begin
					next_launch_q  <= wc_q + {16'd0, seg_q - {1'b0, xf_q}};
					start_q[sel]   <= wc_q;
					len_q[sel]     <= seg_q;
					fade_q[sel]    <= xf_q;
					sidx_q[sel]    <= last_wp_q;
					active_q[sel]  <= 1'b1;
					slot_q         <= ~sel;
				end else begin
					next_launch_q <= nl;
				end
			end
			if (state_q == ST_WET) begin
				last_wet_q <= wet;
				active_q   <= active_q & ~ended;
			end
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dry_q <= in_sample;
		end
		case (state_q)
			ST_MULFB: fbp_q <= $signed({1'b0, fb_c}) * last_wet_q;
			ST_ADDR0: begin
				live_q   <= live;
				infade_q <= live & in_fade;
				idx1_q   <= idx[1];
			end
			ST_ADDR1: smp_q[0] <= ram_rdata;
			ST_DATA1: smp_q[1] <= ram_rdata;
			ST_TERM: begin
				for (int g = 0; g < 2; g++) begin
					prod_q[g] <= smp_q[g] * $signed({1'b0, w_sel[g]});
				end
			end
			ST_MIX: begin
				pm_q <= $signed({1'b0, mix_c}) * last_wet_q;
				pd_q <= $signed({1'b0, dmix_c}) * dry_q;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_sample_q <= res;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	// ------------------------------------------------------------------
	// Capture ring and fade units
	// ------------------------------------------------------------------
	rge_ram #(
		.WIDTH (RING_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rge_fade u_fade0 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fade_req[0]),
		.rsp    (fade_rsp[0])
	);

	rge_fade u_fade1 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fade_req[1]),
		.rsp    (fade_rsp[1])
	);

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef ASSERT_OFF
	a_fade_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TERM) |-> (!fade_rsp[0].busy && !fade_rsp[1].busy))
		else $error("grain terms formed while a fade weight is still in progress");

	a_primed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		primed_q |=> primed_q)
		else $error("primed flag dropped without reset");

	a_grain_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!active_q[0] || (len_q[0] >= SEG_MIN && fade_q[0] != '0 &&
			fade_q[0] <= len_q[0][SEG_W-1:1])) &&
		(!active_q[1] || (len_q[1] >= SEG_MIN && fade_q[1] != '0 &&
			fade_q[1] <= len_q[1][SEG_W-1:1])))
		else $error("active grain has an illegal length or crossfade");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result presented outside the output step");
`endif

endmodule
`default_nettype wire

// ----- sim/reverse_grain_echo_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reverse_grain_echo_tb: self-checking bench for the reverse grain echo
// Drives audio samples through the valid/ready input channel and programs
// the gains and segment length over the APB-style port. A bit-exact
// predictor of the echo runs beside the block, and every output transfer is
// compared with the oldest predicted sample. Phases change the register
// settings and the amount of idling on both channels.
// ----------------------------------------------------------------------------
module reverse_grain_echo_tb;
	import rge_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int MAX_SEG     = 48000;
	localparam int RING_SIZE   = 131072;
	// A correct run of about 1800 samples, with sender gaps and heavy output
	// stalls, stays well below this limit.
	localparam int CYCLE_LIMIT = 1000000;
	// The tail wait exceeds the input to output latency.
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_SHOWN   = 10;
	localparam int MAX_GAP     = 40;
	localparam int PHASES      = 11;
	localparam int PHASE_ITEMS = 150;

	// Byte address 12 decodes to no register; writes there must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

	// Every input starts at a known value at time zero.
	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     psel      = 1'b0;
	logic                     penable   = 1'b0;
	logic                     pwrite    = 1'b0;
	logic [ADDR_W-1:0]        paddr     = '0;
	logic [DATA_W-1:0]        pwdata    = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic signed [SMP_W-1:0]  in_sample = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [OUT_W-1:0]  out_sample;

	// Percent of transfers preceded by a sender gap, and percent of cycles in
	// which the receiver holds out_ready low.
	int idle_pct  = 0;
	int stall_pct = 0;

	int err_cnt   = 0;
	int cycle_cnt = 0;

	// Output samples predicted for accepted inputs, oldest first.
	logic signed [OUT_W-1:0] pending_out [$];

	// Predictor copy of the register file.
	bit [SEG_W-1:0]  seg_reg = SEG_RESET;
	bit [GAIN_W-1:0] fb_reg  = FB_RESET;
	bit [MIX_W-1:0]  mix_reg = MIX_RESET;

	// Predictor copy of the echo state. The ring is left unknown on purpose:
	// the stimulus never lets a grain reach an entry that was not captured,
	// and if it ever did, the unknown value would show up as a mismatch.
	logic signed [RING_W-1:0] cap_ring [RING_SIZE];
	bit [CNT_W-1:0]  wr_cnt     = '0;
	bit [CNT_W-1:0]  nxt_launch = '0;
	bit [CNT_W-1:0]  g_start [2];
	bit [SEG_W-1:0]  g_len   [2];
	bit [FADE_W-1:0] g_fade  [2];
	bit              g_act   [2];
	bit              slot_ptr   = 1'b0;
	bit              primed     = 1'b0;
	longint          prev_wet   = 0;

	reverse_grain_echo #(
		.MAX_SEGMENT(MAX_SEG),
		.RING_DEPTH (RING_SIZE)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_sample (in_sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_sample(out_sample)
	);

	always #CLK_HALF clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Product with a Q0.16 gain, rounded half up. The arithmetic shift of a
	// signed value is a floor, which is what the rounding needs.
	function automatic longint round_q16(longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Equal-power fade weight sin(pi/2 * x), x and result in Q0.16. Each
	// product of the odd polynomial is truncated by 16 bits.
	function automatic longint unsigned sine_weight(longint unsigned x);
		longint unsigned x2, t;
		x2 = (x * x) >> 16;
		t  = POLY_C - ((x2 * POLY_D) >> 16);
		t  = POLY_B - ((x2 * t) >> 16);
		t  = POLY_A - ((x2 * t) >> 16);
		t  = (x * t) >> 16;
		return (t > UNITY) ? UNITY : t;
	endfunction

	// Contribution of one grain slot to the current wet sample. A grain
	// plays the segment captured before its launch, newest sample first.
	function automatic longint grain_term(int g);
		bit [CNT_W-1:0] seg, xf, age, num, idx;
		longint unsigned w;
		w = UNITY;
		if (!g_act[g])
			return 0;
		seg = g_len[g];
		if (seg < 2)
			return 0;
		age = wr_cnt - g_start[g];
		if (age >= seg)
			return 0;
		idx = (g_start[g] - 32'd1 - age) % RING_SIZE;
		xf = g_fade[g];
		if (xf < 1)
			xf = 1;
		if (xf > seg / 2)
			xf = seg / 2;
		if (age < xf || age >= seg - xf) begin
			num = (age < xf) ? age : (seg - 32'd1 - age);
			w = sine_weight({num, 16'h0} / xf);
		end
		return round_q16(longint'(cap_ring[idx]) * longint'(w));
	endfunction

	// Advances the echo by one accepted sample and returns its output.
	function automatic logic signed [OUT_W-1:0] echo_predict(logic signed [SMP_W-1:0] dry_in);
		longint dry, fb, mix, fed, wet;
		bit [CNT_W-1:0] seg, xf;
		int g;
		dry = dry_in;
		fb  = (fb_reg > FB_CAP) ? FB_CAP : fb_reg;
		mix = (mix_reg > UNITY) ? UNITY : mix_reg;

		// Dry plus recycled wet goes into the ring, saturated to about 4.0.
		fed = clip(dry + round_q16(fb * prev_wet), longint'(CAP_LO), longint'(CAP_HI));
		cap_ring[wr_cnt % RING_SIZE] = fed[RING_W-1:0];
		wr_cnt++;

		seg = seg_reg;
		if (seg < SEG_MIN)
			seg = SEG_MIN;
		if (seg > MAX_SEG)
			seg = MAX_SEG;
		if (seg > RING_SIZE)
			seg = RING_SIZE;
		xf = seg * 3 / 20;
		if (xf < 1)
			xf = 1;
		if (xf > seg / 2)
			xf = seg / 2;

		// The first grain waits until one whole segment has been captured.
		if (!primed && wr_cnt >= seg) begin
			primed     = 1'b1;
			nxt_launch = wr_cnt;
		end
		// Launch times are compared modulo 2^32, as the counters wrap.
		if (primed && (wr_cnt - nxt_launch) < 32'h8000_0000) begin
			g = slot_ptr;
			// A slot still playing ahead of its fade-out is left alone.
			if (g_act[g] && (wr_cnt - g_start[g]) <
					(32'(g_len[g]) - 32'(g_fade[g])))
				g ^= 1;
			g_start[g] = wr_cnt;
			g_len[g]   = seg[SEG_W-1:0];
			g_fade[g]  = xf[FADE_W-1:0];
			g_act[g]   = 1'b1;
			slot_ptr   = (g == 0);
			nxt_launch = wr_cnt + (seg - xf);
		end

		wet = clip(grain_term(0) + grain_term(1), longint'(OUT_LO), longint'(OUT_HI));
		for (g = 0; g < 2; g++) begin
			if (g_act[g] && (wr_cnt - g_start[g]) >= g_len[g])
				g_act[g] = 1'b0;
		end
		prev_wet = wet;

		return OUT_W'(clip(round_q16(mix * wet + (longint'(UNITY) - mix) * dry),
			longint'(OUT_LO), longint'(OUT_HI)));
	endfunction

	// ------------------------------------------------------------------------
	// Checking and run control
	// ------------------------------------------------------------------------

	task automatic flag_error(string what, longint want, longint got);
		err_cnt++;
		if (err_cnt <= MAX_SHOWN)
			$display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// Each output transfer is compared with the oldest prediction. Sampling
	// at the rising edge sees the values from before the edge, so the result
	// does not depend on event order.
	always @(posedge clk) begin : check_out
		logic signed [OUT_W-1:0] want;
		if (out_valid && out_ready) begin
			if (pending_out.size() == 0) begin
				flag_error("output transfer with no sample pending", 0, out_sample);
			end else begin
				want = pending_out.pop_front();
				if (out_sample !== want)
					flag_error("out_sample", want, out_sample);
			end
		end
	end

	// The receiver stalls at random for the share of cycles the phase asks.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Guard against a block that stops answering.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("reverse_grain_echo_tb: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Shared stimulus tasks
	// ------------------------------------------------------------------------

	// Offers one sample and returns at the edge where the transfer happens.
	// When no gap is drawn, in_valid simply stays high for the next sample.
	task automatic send_sample(logic signed [SMP_W-1:0] s);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		in_sample <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_out.push_back(echo_predict(s));
	endtask

	// Stops offering samples and waits until every predicted output has
	// been transferred. Every sample yields one output, so the block is
	// idle once the queue is empty.
	task automatic wait_drained();
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
	endtask

	// APB write: a setup cycle, then an access cycle. pready is always high,
	// so the register takes the value at the end of the access cycle. The
	// bus then rests idle before the next access may start.
	task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_SEGMENT:  seg_reg = value[SEG_W-1:0];
			REG_FEEDBACK: fb_reg  = value[GAIN_W-1:0];
			REG_MIX:      mix_reg = value[MIX_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		idle_pct  = send_pct;
		stall_pct = recv_pct;
	endtask

	// Mostly random full-scale audio, with the rails and quiet samples mixed
	// in so that every input bit toggles and rounding near zero is exercised.
	function automatic logic signed [SMP_W-1:0] pick_sample();
		int unsigned r;
		bit [31:0] raw;
		r   = $urandom_range(99);
		raw = $urandom;
		if (r < 4)
			return SMP_MAX;
		if (r < 8)
			return SMP_MIN;
		if (r < 25)
			return SMP_W'($signed(raw[7:0]));
		return raw[SMP_W-1:0];
	endfunction

	// Most segments are short so that many grains launch, retire and overlap
	// within a phase. A longer segment is never allowed past the number of
	// samples captured so far, so no grain reaches into unwritten ring space.
	function automatic bit [DATA_W-1:0] pick_segment();
		bit [DATA_W-1:0] v;
		case ($urandom_range(9))
			0:       v = $urandom_range(0, 3);
			1:       v = $urandom_range(301, MAX_SEG);
			2, 3:    v = $urandom_range(81, 300);
			default: v = $urandom_range(4, 80);
		endcase
		if (v > wr_cnt)
			v = wr_cnt;
		return v;
	endfunction

	function automatic bit [DATA_W-1:0] pick_feedback();
		case ($urandom_range(4))
			0:       return 0;
			1:       return FB_CAP;
			2:       return {GAIN_W{1'b1}};
			default: return $urandom_range(FB_CAP);
		endcase
	endfunction

	function automatic bit [DATA_W-1:0] pick_mix();
		case ($urandom_range(4))
			0:       return 0;
			1:       return UNITY;
			2:       return {MIX_W{1'b1}};
			default: return $urandom_range(UNITY);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// All ones in every register: the segment, the feedback and the mix are
	// all clamped on use, and the write past the last register must change
	// nothing. The segment is far longer than this run gets, so the output is
	// pure wet (silence) at full mix and pure dry at zero mix.
	task automatic test_register_extremes();
		set_idling(0, 0);
		write_reg(REG_SEGMENT, '1);
		write_reg(REG_FEEDBACK, '1);
		write_reg(REG_MIX, '1);
		write_reg(REG_UNUSED, '1);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample('0);
		send_sample('1);
		wait_drained();
		write_reg(REG_MIX, '0);
		send_sample(SMP_MIN);
		send_sample(SMP_MAX);
		send_sample('1);
		send_sample('0);
		wait_drained();
	endtask

	// Segment values of zero and one are raised to the two-sample minimum,
	// where the crossfade is one sample and both grain ends carry no weight.
	// Three samples is the shortest segment with an unfaded middle.
	task automatic test_shortest_segment();
		write_reg(REG_FEEDBACK, '0);
		write_reg(REG_MIX, UNITY);
		write_reg(REG_SEGMENT, 0);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		wait_drained();
		write_reg(REG_SEGMENT, 1);
		send_sample(SMP_MIN);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(SMP_MAX);
		wait_drained();
		write_reg(REG_SEGMENT, 3);
		send_sample(SMP_MAX);
		send_sample(SMP_MAX);
		send_sample(SMP_MIN);
		send_sample(SMP_MIN);
		wait_drained();
	endtask

	// A held full-scale input with the largest feedback builds the recycled
	// signal up until the capture clamp takes over, first positive and then
	// negative. In between the sender holds off until the block has delivered
	// every pending output, so the negative run starts from a fully quiet
	// pipeline with the grains still carrying old audio.
	task automatic test_saturation();
		set_idling(11, 11);
		write_reg(REG_SEGMENT, 8);
		write_reg(REG_FEEDBACK, FB_CAP);
		write_reg(REG_MIX, UNITY);
		repeat (64) send_sample(SMP_MAX);
		wait_drained();
		repeat (64) send_sample(SMP_MIN);
		wait_drained();
	endtask

	// Random audio under changing settings and idling. Segment changes in
	// both directions between phases also reach the case where the preferred
	// grain slot is still playing and the launch moves to the other slot.
	task automatic test_random_phases();
		int p;
		for (p = 0; p < PHASES; p++) begin
			case (p % 4)
				0:       set_idling(0, 0);
				1:       set_idling(51, 0);
				2:       set_idling(0, 51);
				default: set_idling(11, 11);
			endcase
			wait_drained();
			write_reg(REG_SEGMENT, pick_segment());
			write_reg(REG_FEEDBACK, pick_feedback());
			write_reg(REG_MIX, pick_mix());
			repeat (PHASE_ITEMS) send_sample(pick_sample());
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_register_extremes();
		test_shortest_segment();
		test_saturation();
		test_random_phases();

		// Let the last outputs arrive, then give the block its latency once
		// more so that any stray transfer is still caught.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_out.size() != 0)
			flag_error("outputs never transferred", pending_out.size(), 0);

		if (err_cnt == 0)
			$display("reverse_grain_echo_tb: clean");
		else
			$display("reverse_grain_echo_tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/rge_pkg.sv
sv/rge_ram.sv
sv/rge_fade.sv
sv/reverse_grain_echo.sv
sim/reverse_grain_echo_tb.sv
